// ===== rtl/sle_pkg.sv =====
package sle_pkg;

  localparam int DEPTH      = 1024;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int QDEPTH     = 2;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [2:0] FUNC_CLEAR  = 3'd0;
  localparam logic [2:0] FUNC_INSERT = 3'd1;
  localparam logic [2:0] FUNC_DELETE = 3'd2;
  localparam logic [2:0] FUNC_GET    = 3'd3;
  localparam logic [2:0] FUNC_LOCATE = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_POS  = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_INSERT,
    OP_DELETE,
    OP_GET,
    OP_LOCATE
  } op_t;

  typedef struct packed {
    logic [2:0]            func;
    logic [CNT_W-1:0]      position;
    logic [DATA_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [DATA_WIDTH-1:0] data;
    logic                  found;
    logic [IDX_W-1:0]      found_index;
    logic [CNT_W-1:0]      list_count;
  } rsp_t;

  // Classified request handed from the front end to the memory sequencer.
  typedef struct packed {
    op_t                   op;
    logic [1:0]            status;
    logic [IDX_W-1:0]      idx;
    logic [CNT_W-1:0]      len_before;
    logic [CNT_W-1:0]      list_count;
    logic [DATA_WIDTH-1:0] value;
  } cmd_t;

endpackage

// ===== rtl/sle_ram.sv =====
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sle_front.sv =====
module sle_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  sle_pkg::req_t       req,
  input  logic                q_full,
  output logic                push,
  output sle_pkg::cmd_t       push_cmd
);

  logic [sle_pkg::CNT_W-1:0] len;
  logic [sle_pkg::CNT_W-1:0] len_next;
  logic [sle_pkg::CNT_W:0]   len_p1;
  logic                      pos_nz;
  logic                      pos_ok;
  logic                      ins_ok;
  logic                      full;

  assign req_ready = !q_full;
  assign push      = req_valid && !q_full;

  assign len_p1 = {1'b0, len} + (sle_pkg::CNT_W + 1)'(1);
  assign pos_nz = req.position != '0;
  assign pos_ok = pos_nz && (req.position <= len);
  assign ins_ok = pos_nz && ({1'b0, req.position} <= len_p1);
  assign full   = len == sle_pkg::CNT_W'(sle_pkg::DEPTH);

  // The length follows from the request stream alone, so resolve status here.
  always_comb begin
    len_next            = len;
    push_cmd.op         = sle_pkg::OP_NONE;
    push_cmd.status     = sle_pkg::ST_OK;
    push_cmd.idx        = sle_pkg::IDX_W'(req.position - sle_pkg::CNT_W'(1));
    push_cmd.len_before = len;
    push_cmd.value      = req.value;
    unique case (req.func)
      sle_pkg::FUNC_CLEAR: begin
        len_next = '0;
      end
      sle_pkg::FUNC_INSERT: begin
        if (!ins_ok) begin
          push_cmd.status = sle_pkg::ST_POS;
        end else if (full) begin
          push_cmd.status = sle_pkg::ST_FULL;
        end else begin
          push_cmd.op = sle_pkg::OP_INSERT;
          len_next    = len_p1[sle_pkg::CNT_W-1:0];
        end
      end
      sle_pkg::FUNC_DELETE: begin
        if (!pos_ok) begin
          push_cmd.status = sle_pkg::ST_POS;
        end else begin
          push_cmd.op = sle_pkg::OP_DELETE;
          len_next    = len - sle_pkg::CNT_W'(1);
        end
      end
      sle_pkg::FUNC_GET: begin
        if (!pos_ok) begin
          push_cmd.status = sle_pkg::ST_POS;
        end else begin
          push_cmd.op = sle_pkg::OP_GET;
        end
      end
      sle_pkg::FUNC_LOCATE: begin
        push_cmd.op = sle_pkg::OP_LOCATE;
      end
      default: begin
      end
    endcase
    push_cmd.list_count = len_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      len <= '0;
    end else if (push) begin
      len <= len_next;
    end
  end

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= sle_pkg::CNT_W'(sle_pkg::DEPTH))
    else $error("list length beyond capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (rst)
    push && push_cmd.op == sle_pkg::OP_INSERT |-> !full && ins_ok)
    else $error("insert issued without room or valid position");

endmodule

// ===== rtl/sle_queue.sv =====
module sle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sle_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output sle_pkg::cmd_t pop_cmd,
  output logic          empty
);

  sle_pkg::cmd_t              slots [sle_pkg::QDEPTH];
  logic [sle_pkg::QPTR_W-1:0] wr_ptr;
  logic [sle_pkg::QPTR_W-1:0] rd_ptr;
  logic [sle_pkg::QPTR_W:0]   count;

  assign full    = count == (sle_pkg::QPTR_W + 1)'(sle_pkg::QDEPTH);
  assign empty   = count == '0;
  assign pop_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + sle_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + sle_pkg::QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (sle_pkg::QPTR_W + 1)'(1);
        2'b01:   count <= count - (sle_pkg::QPTR_W + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sle_back.sv =====
module sle_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_empty,
  input  sle_pkg::cmd_t q_cmd,
  output logic          pop,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sle_pkg::rsp_t rsp
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_RESP
  } state_t;

  state_t                         state;
  sle_pkg::cmd_t                  cmd_q;
  logic [sle_pkg::IDX_W-1:0]      rd_ptr;
  logic [sle_pkg::CNT_W-1:0]      remain;
  logic                           rv;
  logic [sle_pkg::IDX_W-1:0]      rtag;
  logic [sle_pkg::DATA_WIDTH-1:0] data_acc;
  logic                           hit;
  logic [sle_pkg::IDX_W-1:0]      where_idx;

  logic                           issue;
  logic                           ram_we;
  logic [sle_pkg::IDX_W-1:0]      ram_waddr;
  logic [sle_pkg::DATA_WIDTH-1:0] ram_wdata;
  logic [sle_pkg::DATA_WIDTH-1:0] ram_rdata;
  logic [sle_pkg::IDX_W-1:0]      start_ptr;
  logic [sle_pkg::CNT_W-1:0]      start_cnt;
  logic [sle_pkg::CNT_W-1:0]      tail_cnt;

  sle_ram #(
    .WIDTH (sle_pkg::DATA_WIDTH),
    .DEPTH (sle_pkg::DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign pop   = state == S_IDLE && !q_empty;
  assign issue = state == S_RUN && remain != '0;

  // Entries from idx to the end of the list move for insert and delete.
  assign tail_cnt = q_cmd.len_before - {1'b0, q_cmd.idx};

  always_comb begin
    start_ptr = '0;
    start_cnt = '0;
    unique case (q_cmd.op)
      sle_pkg::OP_NONE: begin
      end
      sle_pkg::OP_GET: begin
        start_ptr = q_cmd.idx;
        start_cnt = sle_pkg::CNT_W'(1);
      end
      sle_pkg::OP_DELETE: begin
        start_ptr = q_cmd.idx;
        start_cnt = tail_cnt;
      end
      sle_pkg::OP_INSERT: begin
        start_ptr = sle_pkg::IDX_W'(q_cmd.len_before - sle_pkg::CNT_W'(1));
        start_cnt = tail_cnt;
      end
      sle_pkg::OP_LOCATE: begin
        start_cnt = q_cmd.len_before;
      end
      default: begin
      end
    endcase
  end

  // Write back each word the cycle after its read: up one slot for insert,
  // down one slot for delete (the removed word itself is not written).
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rtag;
    ram_wdata = ram_rdata;
    if (state == S_RUN && rv) begin
      if (cmd_q.op == sle_pkg::OP_INSERT) begin
        ram_we    = 1'b1;
        ram_waddr = rtag + sle_pkg::IDX_W'(1);
      end else if (cmd_q.op == sle_pkg::OP_DELETE && rtag != cmd_q.idx) begin
        ram_we    = 1'b1;
        ram_waddr = rtag - sle_pkg::IDX_W'(1);
      end
    end else if (state == S_RESP && cmd_q.op == sle_pkg::OP_INSERT) begin
      ram_we    = 1'b1;
      ram_waddr = cmd_q.idx;
      ram_wdata = cmd_q.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rv        <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      // In S_RESP the response step below owns rsp_valid.
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          rv <= 1'b0;
          if (!q_empty) begin
            cmd_q     <= q_cmd;
            rd_ptr    <= start_ptr;
            remain    <= start_cnt;
            data_acc  <= '0;
            hit       <= 1'b0;
            where_idx <= '0;
            state     <= S_RUN;
          end
        end
        S_RUN: begin
          rv   <= issue;
          rtag <= rd_ptr;
          if (issue) begin
            remain <= remain - sle_pkg::CNT_W'(1);
            if (cmd_q.op == sle_pkg::OP_INSERT) begin
              rd_ptr <= rd_ptr - sle_pkg::IDX_W'(1);
            end else begin
              rd_ptr <= rd_ptr + sle_pkg::IDX_W'(1);
            end
          end
          if (rv) begin
            if (cmd_q.op == sle_pkg::OP_GET ||
                (cmd_q.op == sle_pkg::OP_DELETE && rtag == cmd_q.idx)) begin
              data_acc <= ram_rdata;
            end
            // Later matches overwrite, so the last index wins.
            if (cmd_q.op == sle_pkg::OP_LOCATE && ram_rdata == cmd_q.value) begin
              hit       <= 1'b1;
              where_idx <= rtag;
            end
          end
          if (!issue && !rv) begin
            state <= S_RESP;
          end
        end
        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp.status      <= cmd_q.status;
            rsp.data        <= data_acc;
            rsp.found       <= hit;
            rsp.found_index <= where_idx;
            rsp.list_count  <= cmd_q.list_count;
            rsp_valid       <= 1'b1;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !rv)
    else $error("read still in flight while idle");

  a_shift_write: assert property (@(posedge clk) disable iff (rst)
    ram_we && state == S_RUN |->
      cmd_q.op == sle_pkg::OP_INSERT || cmd_q.op == sle_pkg::OP_DELETE)
    else $error("store written by a read-only request");

  a_get_single: assert property (@(posedge clk) disable iff (rst)
    state == S_RUN && cmd_q.op == sle_pkg::OP_GET |-> remain <= sle_pkg::CNT_W'(1))
    else $error("get issued more than one read");

  a_resp_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_RESP)
    else $error("response raised outside the response step");

endmodule

// ===== rtl/sequential_list_engine_top.sv =====
// Ordered list of up to DEPTH 32-bit words kept in a single-port-write RAM.
// Requests arrive on req (valid/ready) as func, position and value; each one
// produces exactly one response on rsp (valid/ready): status, data, found,
// found_index and the list length after the request.
// The front end resolves status and the new length as soon as a request is
// accepted and queues it (two entries); the back end then walks the RAM,
// one read and one write per cycle, and fills the response register.
// Each request passes the back end states S_IDLE, S_RUN and S_RESP. In S_RUN
// it makes one RAM read for get, length - pos + 1 reads for delete and
// insert, length reads for locate and none for the rest.
// Reset (rst, synchronous) empties the list and drops queued and pending
// requests; no RAM clearing pass is needed since only entries below the
// current length are ever read.
// When the receiver holds rsp_ready low the finished response waits in the
// output register; the back end stops before its next response and the
// queue then fills, after which req_ready falls.
module sequential_list_engine_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  sle_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output sle_pkg::rsp_t rsp
);

  logic          push;
  sle_pkg::cmd_t push_cmd;
  logic          q_full;
  logic          pop;
  sle_pkg::cmd_t q_cmd;
  logic          q_empty;

  sle_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  sle_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .pop_cmd  (q_cmd),
    .empty    (q_empty)
  );

  sle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule

// ===== sim/sequential_list_engine_top_tb.sv =====
module sequential_list_engine_top_tb;

  // func codes the block has no use for
  localparam logic [2:0] FUNC_RSVD_A = 3'd5;
  localparam logic [2:0] FUNC_RSVD_B = 3'd6;
  localparam logic [2:0] FUNC_RSVD_C = 3'd7;

  localparam int HOLD_CYCLES = 400;
  localparam int POS_MAX     = (1 << sle_pkg::CNT_W) - 1;

  typedef struct packed {
    sle_pkg::req_t stim;
    bit            typed;
    sle_pkg::rsp_t want;
  } dir_row_t;

  logic          clk       = 1'b0;
  logic          rst       = 1'b1;
  logic          req_valid = 1'b0;
  logic          req_ready;
  sle_pkg::req_t req       = '0;
  logic          rsp_valid;
  logic          rsp_ready = 1'b0;
  sle_pkg::rsp_t rsp;

  // shadow copy of the list
  logic [sle_pkg::DATA_WIDTH-1:0] list_words [sle_pkg::DEPTH];
  int                             list_len = 0;

  sle_pkg::rsp_t pending_rsp [$];
  dir_row_t      dir_table   [$];
  int            err_count     = 0;
  int            req_idle_pct  = 0;
  int            rsp_stall_pct = 0;
  bit            hold_armed    = 1'b0;
  logic          rsp_hold      = 1'b0;

  sequential_list_engine_top dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #80_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    if (err_count < 40) $display("ERROR: %s", msg);
    err_count++;
  endtask

  // Apply one request to the shadow list and return the response it owes.
  function automatic sle_pkg::rsp_t list_op_result(input sle_pkg::req_t r);
    sle_pkg::rsp_t o;
    int            p;
    int            k;
    o = '0;
    p = int'(r.position);
    case (r.func)
      sle_pkg::FUNC_CLEAR: list_len = 0;
      sle_pkg::FUNC_INSERT: begin
        if (p < 1 || p > list_len + 1) begin
          o.status = sle_pkg::ST_POS;
        end else if (list_len >= sle_pkg::DEPTH) begin
          o.status = sle_pkg::ST_FULL;
        end else begin
          for (k = list_len; k > p - 1; k--) list_words[k] = list_words[k-1];
          list_words[p-1] = r.value;
          list_len++;
        end
      end
      sle_pkg::FUNC_DELETE: begin
        if (p < 1 || p > list_len) begin
          o.status = sle_pkg::ST_POS;
        end else begin
          o.data = list_words[p-1];
          for (k = p - 1; k + 1 < list_len; k++) list_words[k] = list_words[k+1];
          list_len--;
        end
      end
      sle_pkg::FUNC_GET: begin
        if (p < 1 || p > list_len) o.status = sle_pkg::ST_POS;
        else o.data = list_words[p-1];
      end
      sle_pkg::FUNC_LOCATE: begin
        for (k = 0; k < list_len; k++) begin
          if (list_words[k] == r.value) begin
            o.found       = 1'b1;
            o.found_index = sle_pkg::IDX_W'(k);
          end
        end
      end
      default: ;
    endcase
    o.list_count = sle_pkg::CNT_W'(list_len);
    return o;
  endfunction

  function automatic dir_row_t mk_row(input logic [2:0] f, input int p,
                                      input logic [sle_pkg::DATA_WIDTH-1:0] v,
                                      input bit typed, input logic [1:0] st,
                                      input logic [sle_pkg::DATA_WIDTH-1:0] d,
                                      input int cnt);
    dir_row_t row;
    row.stim.func        = f;
    row.stim.position    = sle_pkg::CNT_W'(p);
    row.stim.value       = v;
    row.typed            = typed;
    row.want             = '0;
    row.want.status      = st;
    row.want.data        = d;
    row.want.list_count  = sle_pkg::CNT_W'(cnt);
    return row;
  endfunction

  function automatic sle_pkg::req_t random_request();
    sle_pkg::req_t r;
    int            pick;
    r.value = $urandom();
    // draw from a few edge words so locate sees repeats
    if ($urandom_range(0, 3) == 0) begin
      case ($urandom_range(0, 3))
        0:       r.value = '0;
        1:       r.value = '1;
        2:       r.value = 32'h8000_0001;
        default: r.value = 32'h5A5A_A5A5;
      endcase
    end
    pick = $urandom_range(0, 99);
    if (pick < 3) r.func = sle_pkg::FUNC_CLEAR;
    else if (pick < 7) r.func = 3'($urandom_range(FUNC_RSVD_A, FUNC_RSVD_C));
    else if (pick < (list_len > 40 ? 28 : 44)) r.func = sle_pkg::FUNC_INSERT;
    else if (pick < 64) r.func = sle_pkg::FUNC_DELETE;
    else if (pick < 82) r.func = sle_pkg::FUNC_GET;
    else r.func = sle_pkg::FUNC_LOCATE;

    case ($urandom_range(0, 9))
      0: r.position = sle_pkg::CNT_W'($urandom_range(0, POS_MAX));
      1: r.position = (r.func == sle_pkg::FUNC_INSERT) ? sle_pkg::CNT_W'(list_len + 2)
                                                       : sle_pkg::CNT_W'(list_len + 1);
      2: r.position = '0;
      default: begin
        if (r.func == sle_pkg::FUNC_INSERT)
          r.position = sle_pkg::CNT_W'($urandom_range(1, list_len + 1));
        else if (list_len == 0) r.position = sle_pkg::CNT_W'(1);
        else r.position = sle_pkg::CNT_W'($urandom_range(1, list_len));
      end
    endcase
    if (r.func == sle_pkg::FUNC_LOCATE && list_len > 0 && $urandom_range(0, 2) != 0)
      r.value = list_words[$urandom_range(0, list_len - 1)];
    return r;
  endfunction

  // Offer one request, hold it until accepted, then record what it owes.
  task automatic push_request(input sle_pkg::req_t r, input bit typed,
                              input sle_pkg::rsp_t want);
    sle_pkg::rsp_t predicted;
    while ($urandom_range(0, 99) < req_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    predicted = list_op_result(r);
    pending_rsp.push_back(typed ? want : predicted);
  endtask

  task automatic send_op(input logic [2:0] f, input int p,
                         input logic [sle_pkg::DATA_WIDTH-1:0] v);
    sle_pkg::req_t r;
    r.func     = f;
    r.position = sle_pkg::CNT_W'(p);
    r.value    = v;
    push_request(r, 1'b0, '0);
  endtask

  task automatic run_random(input int idle_pct, input int stall_pct, input int count);
    req_idle_pct  = idle_pct;
    rsp_stall_pct = stall_pct;
    repeat (count) push_request(random_request(), 1'b0, '0);
  endtask

  task automatic drain_responses();
    req_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
  endtask

  task automatic check_response(input sle_pkg::rsp_t got);
    sle_pkg::rsp_t want;
    if (pending_rsp.size() == 0) begin
      log_mismatch($sformatf("response with nothing outstanding: %p", got));
    end else begin
      want = pending_rsp.pop_front();
      if (got.status != want.status)
        log_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
      if (got.data != want.data)
        log_mismatch($sformatf("data %h, want %h", got.data, want.data));
      if (got.found != want.found)
        log_mismatch($sformatf("found %0d, want %0d", got.found, want.found));
      if (got.found_index != want.found_index)
        log_mismatch($sformatf("found_index %0d, want %0d", got.found_index,
                               want.found_index));
      if (got.list_count != want.list_count)
        log_mismatch($sformatf("list_count %0d, want %0d", got.list_count,
                               want.list_count));
    end
  endtask

  always @(posedge clk) begin
    if (rsp_valid && rsp_ready) check_response(rsp);
    rsp_ready <= !rsp_hold && ($urandom_range(0, 99) >= rsp_stall_pct);
  end

  // Long receiver hold-off so the request queue fills and req_ready drops.
  initial begin
    wait (hold_armed);
    @(posedge clk);
    rsp_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rsp_hold <= 1'b0;
  end

  initial begin
    sle_pkg::req_t r;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    dir_table.push_back(mk_row(sle_pkg::FUNC_GET, 1, '0, 1, sle_pkg::ST_POS, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_DELETE, 0, '0, 1, sle_pkg::ST_POS, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 0, 32'h1, 1, sle_pkg::ST_POS, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 2, 32'h1, 1, sle_pkg::ST_POS, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_LOCATE, 0, '0, 1, sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 1, '1, 1, sle_pkg::ST_OK, '0, 1));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 1, '0, 1, sle_pkg::ST_OK, '0, 2));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 3, '0, 1, sle_pkg::ST_OK, '0, 3));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 2, 32'h1234_5678, 0,
                               sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_GET, 3, '0, 1, sle_pkg::ST_OK, '1, 4));
    dir_table.push_back(mk_row(sle_pkg::FUNC_LOCATE, 0, '0, 0, sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_LOCATE, 0, 32'hDEAD_BEEF, 0,
                               sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_GET, POS_MAX, '0, 1, sle_pkg::ST_POS, '0, 4));
    dir_table.push_back(mk_row(sle_pkg::FUNC_DELETE, 5, '0, 1, sle_pkg::ST_POS, '0, 4));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 6, '1, 1, sle_pkg::ST_POS, '0, 4));
    dir_table.push_back(mk_row(FUNC_RSVD_A, 1, '1, 1, sle_pkg::ST_OK, '0, 4));
    dir_table.push_back(mk_row(FUNC_RSVD_B, POS_MAX, '1, 1, sle_pkg::ST_OK, '0, 4));
    dir_table.push_back(mk_row(FUNC_RSVD_C, 2, '0, 1, sle_pkg::ST_OK, '0, 4));
    dir_table.push_back(mk_row(sle_pkg::FUNC_DELETE, 1, '1, 0, sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_DELETE, 3, '0, 0, sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_GET, 2, '0, 0, sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_INSERT, 3, 32'hA5A5_5A5A, 0,
                               sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_CLEAR, 0, '0, 1, sle_pkg::ST_OK, '0, 0));
    dir_table.push_back(mk_row(sle_pkg::FUNC_GET, 1, '0, 1, sle_pkg::ST_POS, '0, 0));
    foreach (dir_table[i])
      push_request(dir_table[i].stim, dir_table[i].typed, dir_table[i].want);

    run_random(0, 0, 125);
    run_random(74, 0, 125);

    // sender keeps pushing while the receiver is held off
    req_idle_pct  = 0;
    rsp_stall_pct = 0;
    hold_armed    = 1'b1;
    repeat (20) push_request(random_request(), 1'b0, '0);
    drain_responses();

    // fill the list to capacity, mostly appending
    send_op(sle_pkg::FUNC_CLEAR, 0, '0);
    while (list_len < sle_pkg::DEPTH) begin
      r.func     = sle_pkg::FUNC_INSERT;
      r.value    = $urandom();
      r.position = sle_pkg::CNT_W'(list_len + 1);
      if ($urandom_range(0, 9) == 0) begin
        r.position = sle_pkg::CNT_W'($urandom_range(list_len > 3 ? list_len - 3 : 1,
                                                    list_len + 1));
      end else if ($urandom_range(0, 19) == 0) begin
        r.func     = sle_pkg::FUNC_GET;
        r.position = sle_pkg::CNT_W'($urandom_range(1, list_len + 1));
      end
      push_request(r, 1'b0, '0);
    end

    req_idle_pct  = 27;
    rsp_stall_pct = 27;
    send_op(sle_pkg::FUNC_INSERT, sle_pkg::DEPTH + 1, $urandom());
    send_op(sle_pkg::FUNC_INSERT, 1,                  $urandom());
    send_op(sle_pkg::FUNC_INSERT, sle_pkg::DEPTH + 2, $urandom());
    send_op(sle_pkg::FUNC_GET,    sle_pkg::DEPTH,     '0);
    send_op(sle_pkg::FUNC_GET,    sle_pkg::DEPTH + 1, '0);
    send_op(sle_pkg::FUNC_LOCATE, 0,                  list_words[sle_pkg::DEPTH-1]);
    send_op(sle_pkg::FUNC_LOCATE, 0,                  list_words[0]);
    send_op(sle_pkg::FUNC_DELETE, sle_pkg::DEPTH,     '0);
    send_op(sle_pkg::FUNC_INSERT, sle_pkg::DEPTH,     $urandom());
    send_op(sle_pkg::FUNC_INSERT, 1,                  '1);
    send_op(sle_pkg::FUNC_DELETE, 1,                  '0);
    send_op(sle_pkg::FUNC_INSERT, 1,                  '1);
    send_op(sle_pkg::FUNC_LOCATE, 0,                  $urandom());
    send_op(sle_pkg::FUNC_CLEAR,  POS_MAX,            '1);

    run_random(0, 74, 125);
    run_random(27, 27, 125);

    drain_responses();
    repeat (sle_pkg::DEPTH + 8) @(posedge clk);
    if (err_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
